/* hdl/parallel_flash_command_controller_core_defines.svh */
// assertion macros for the flash command controller
`ifndef PARALLEL_FLASH_COMMAND_CONTROLLER_CORE_DEFINES_SVH
`define PARALLEL_FLASH_COMMAND_CONTROLLER_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define PFCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pfcc_pkg.sv */
// constants and helper functions for the flash command controller
package pfcc_pkg;

  localparam int MAX_BANKS   = 64;
  localparam int BANK_BYTES  = 8192;
  localparam int OFF_W       = 13;
  localparam int BANK_IN_W   = 6;
  localparam int BANK_W      = $clog2(MAX_BANKS);
  localparam int STORE_BYTES = MAX_BANKS * BANK_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PTR_W       = $clog2(STORE_BYTES + 1);
  localparam int CNT_W       = $clog2(MAX_BANKS + 1);
  localparam int SPAN_W      = 21;
  localparam int CADDR_W     = 16;

  localparam int SECT16_SHIFT = 14;
  localparam int SECT64_SHIFT = 16;

  // chip type codes
  localparam logic [1:0] CHIP_NONE  = 2'd0;
  localparam logic [1:0] CHIP_AM010 = 2'd1;
  localparam logic [1:0] CHIP_AM020 = 2'd2;
  localparam logic [1:0] CHIP_AM040 = 2'd3;

  // command addresses and bytes
  localparam logic [CADDR_W-1:0] UNLOCK1_ADDR = 16'h5555;
  localparam logic [CADDR_W-1:0] UNLOCK2_ADDR = 16'h2AAA;
  localparam logic [7:0] UNLOCK1_DATA     = 8'hAA;
  localparam logic [7:0] UNLOCK2_DATA     = 8'h55;
  localparam logic [7:0] CMD_AUTOSEL      = 8'h90;
  localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [7:0] CMD_ERASE        = 8'h80;
  localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [7:0] CMD_RESET        = 8'hF0;

  // autoselect ids
  localparam logic [7:0] MFR_ID       = 8'h01;
  localparam logic [7:0] DEV_ID_AM010 = 8'h20;
  localparam logic [7:0] DEV_ID_AM040 = 8'hA4;
  localparam logic [7:0] ERASED_BYTE  = 8'hFF;

  function automatic logic [CNT_W-1:0] bank_count(input logic [1:0] ct);
    int n;
    case (ct)
      CHIP_AM010: n = 16;
      CHIP_AM020: n = 32;
      CHIP_AM040: n = 64;
      default:    n = 0;
    endcase
    if (n > MAX_BANKS) n = MAX_BANKS;
    return CNT_W'(n);
  endfunction

  // bank wraps modulo the bank count of the chip
  function automatic logic [ADDR_W-1:0] data_addr(input logic [1:0] ct,
                                                  input logic [BANK_IN_W-1:0] bank,
                                                  input logic [OFF_W-1:0] off);
    logic [CNT_W-1:0]     nb;
    logic [BANK_IN_W-1:0] msk;
    logic [BANK_IN_W-1:0] bm;
    nb  = bank_count(ct);
    msk = BANK_IN_W'(nb - 1'b1);
    bm  = bank & msk;
    return ADDR_W'({bm[BANK_W-1:0], off});
  endfunction

endpackage

/* hdl/parallel_flash_command_controller_core.sv */
// byte-wide flash command controller: command state machine, store and erase sweeper
//
// usage: one access per input beat (cmd, bank, offset, wdata) on the in_valid / in_stall
// channel; one result beat (rdata, mode) per access on out_valid / out_stall.
// a read or program goes through state S_RD: the accepting edge starts the registered
// read of the flash store, the next edge decodes and (for program) writes back the ANDed
// byte through the store's single write port, and loads the output register if it is free.
// in_stall is high from acceptance until the result is registered, so one access is in
// flight at a time and a new access is accepted only after that result is registered.
// an erase command sweeps the store one byte per cycle through the same write port:
// chip erase covers 8192 bytes per bank of the chip type, a sector erase 16384
// (16K sector) or 65536 (64K sector) bytes; the result beat waits in the holding
// register during the sweep and is registered at the output after it ends.
// when the receiver stalls, the output register holds its beat and the next access is
// still accepted; its result waits in a holding register, with in_stall high, until the
// output register drains. reset: a clearing pass writes 0xFF to all 524288 store bytes,
// one per cycle, with in_stall high; chip_type resets to 3 and the command state to read.
// chip_type is written on the cfg channel (always ready); the user must do so only while
// the block is idle, and the block itself does not enforce this.
`include "parallel_flash_command_controller_core_defines.svh"

module parallel_flash_command_controller_core
  import pfcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data,
  // access channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [BANK_IN_W-1:0] bank,
  input  logic [OFF_W-1:0]     offset,
  input  logic [7:0]           wdata,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           rdata,
  output logic [3:0]           mode
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_ERASE,
    S_HOLD
  } state_t;

  // flash command states, codes are visible on the mode output
  typedef enum logic [3:0] {
    CS_READ    = 4'd0,
    CS_SECOND  = 4'd1,
    CS_THIRD   = 4'd2,
    CS_AUTOSEL = 4'd3,
    CS_PROGRAM = 4'd4,
    CS_ERASE1  = 4'd5,
    CS_ERASE2  = 4'd6,
    CS_ERASE   = 4'd7,
    CS_LIMBO   = 4'd8
  } cmd_state_t;

  state_t     state;
  cmd_state_t cs;
  cmd_state_t cs_eff;
  cmd_state_t cs_next;
  logic [1:0] chip_type;

  // latched access
  logic                 it_cmd;
  logic [BANK_IN_W-1:0] it_bank;
  logic [OFF_W-1:0]     it_off;
  logic [7:0]           it_wdata;

  // flash store
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        mem_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // sweeper shared by the clearing pass and the erase commands
  logic [PTR_W-1:0] sweep_ptr;
  logic [PTR_W-1:0] sweep_end;
  logic             sweeping;

  logic [7:0] hold_rdata;
  logic [3:0] hold_mode;

  // decode of the latched access
  logic [CNT_W-1:0]   nb;
  logic               present;
  logic [CADDR_W-1:0] caddr;
  logic [ADDR_W-1:0]  it_daddr;
  logic [7:0]         res_rdata;
  logic               do_program;
  logic               erase_req;
  logic               do_erase;
  logic [SPAN_W-1:0]  limit;
  logic [SPAN_W-1:0]  er_start;
  logic [SPAN_W-1:0]  er_len;
  logic [SPAN_W-1:0]  er_end_raw;
  logic [SPAN_W-1:0]  er_end;
  logic               out_free;
  logic               load_out;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign sweeping  = (state == S_CLEAR) || (state == S_ERASE);

  assign nb       = bank_count(chip_type);
  assign present  = (nb != '0);
  assign caddr    = {it_bank[2:0], it_off};
  assign it_daddr = data_addr(chip_type, it_bank, it_off);
  assign limit    = SPAN_W'(nb) << OFF_W;

  // command state machine and result decode
  always_comb begin
    cs_eff     = (cs == CS_AUTOSEL) ? CS_READ : cs;
    cs_next    = cs;
    do_program = 1'b0;
    erase_req  = 1'b0;
    er_start   = '0;
    er_len     = '0;
    res_rdata  = 8'h00;
    if (!it_cmd) begin
      res_rdata = present ? mem_q : ERASED_BYTE;
      if (cs == CS_AUTOSEL) begin
        if (it_off[7:0] == 8'd0) begin
          res_rdata = present ? MFR_ID : 8'h00;
        end else if (it_off[7:0] == 8'd1) begin
          res_rdata = (chip_type == CHIP_AM010) ? DEV_ID_AM010 :
                      (chip_type == CHIP_AM040) ? DEV_ID_AM040 : 8'h00;
        end
      end
    end else begin
      cs_next = cs_eff;
      case (cs_eff)
        CS_READ: begin
          if (caddr == UNLOCK1_ADDR && it_wdata == UNLOCK1_DATA) cs_next = CS_SECOND;
        end
        CS_SECOND: begin
          if (caddr == UNLOCK2_ADDR && it_wdata == UNLOCK2_DATA) cs_next = CS_THIRD;
        end
        CS_THIRD: begin
          if (caddr == UNLOCK1_ADDR) begin
            if (it_wdata == CMD_AUTOSEL)      cs_next = CS_AUTOSEL;
            else if (it_wdata == CMD_PROGRAM) cs_next = CS_PROGRAM;
            else if (it_wdata == CMD_ERASE)   cs_next = CS_ERASE1;
          end
        end
        CS_PROGRAM: begin
          do_program = present;
          cs_next    = CS_READ;
        end
        CS_ERASE1: begin
          if (caddr == UNLOCK1_ADDR && it_wdata == UNLOCK1_DATA) cs_next = CS_ERASE2;
        end
        CS_ERASE2: begin
          if (caddr == UNLOCK2_ADDR && it_wdata == UNLOCK2_DATA) cs_next = CS_ERASE;
        end
        CS_ERASE: begin
          if (caddr == UNLOCK1_ADDR && it_wdata == CMD_CHIP_ERASE) begin
            erase_req = 1'b1;
            er_start  = '0;
            er_len    = limit;
            cs_next   = CS_READ;
          end else if (it_wdata == CMD_SECTOR_ERASE) begin
            // sector address is not checked; Am020 erases nothing
            if (chip_type == CHIP_AM010) begin
              // 16K sector 1 or 5, picked by the low bank bit
              erase_req = 1'b1;
              er_start  = SPAN_W'({it_bank[0], 2'b01}) << SECT16_SHIFT;
              er_len    = SPAN_W'(1) << SECT16_SHIFT;
            end else if (chip_type == CHIP_AM040) begin
              erase_req = 1'b1;
              er_start  = SPAN_W'(it_bank[5:4]) << SECT64_SHIFT;
              er_len    = SPAN_W'(1) << SECT64_SHIFT;
            end
            cs_next = CS_READ;
          end
        end
        default: begin
          // limbo and unused codes
          if (it_wdata == CMD_RESET) cs_next = CS_READ;
        end
      endcase
    end
  end

  // erase range clamped to the chip size
  assign er_end_raw = er_start + er_len;
  assign er_end     = (er_end_raw > limit) ? limit : er_end_raw;
  assign do_erase   = erase_req && (er_start < limit);

  // output register loads a fresh beat
  assign load_out = out_free && (((state == S_RD) && !do_erase) || (state == S_HOLD));

  // store port selection
  always_comb begin
    rd_en   = accept;
    rd_addr = data_addr(chip_type, bank, offset);
    wr_en   = 1'b0;
    wr_addr = sweep_ptr[ADDR_W-1:0];
    wr_data = ERASED_BYTE;
    if (sweeping) begin
      wr_en = 1'b1;
    end else if (state == S_RD && do_program) begin
      wr_en   = 1'b1;
      wr_addr = it_daddr;
      wr_data = mem_q & it_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cs        <= CS_READ;
      chip_type <= CHIP_AM040;
      sweep_ptr <= '0;
      sweep_end <= PTR_W'(STORE_BYTES);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) chip_type <= cfg_data;
      if (out_valid && !out_stall && !load_out) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          sweep_ptr <= sweep_ptr + 1'b1;
          if (sweep_ptr + 1'b1 == sweep_end) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            it_cmd   <= cmd;
            it_bank  <= bank;
            it_off   <= offset;
            it_wdata <= wdata;
            state    <= S_RD;
          end
        end
        S_RD: begin
          cs <= cs_next;
          if (do_erase) begin
            sweep_ptr  <= PTR_W'(er_start);
            sweep_end  <= PTR_W'(er_end);
            hold_rdata <= res_rdata;
            hold_mode  <= cs_next;
            state      <= S_ERASE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            rdata     <= res_rdata;
            mode      <= cs_next;
            state     <= S_IDLE;
          end else begin
            hold_rdata <= res_rdata;
            hold_mode  <= cs_next;
            state      <= S_HOLD;
          end
        end
        S_ERASE: begin
          sweep_ptr <= sweep_ptr + 1'b1;
          if (sweep_ptr + 1'b1 == sweep_end) state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            rdata     <= hold_rdata;
            mode      <= hold_mode;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PFCC_ASSERT_NEXT(a_accept_to_read, accept, state == S_RD, "accept without store read")
  `PFCC_ASSERT(a_no_write_idle, wr_en |-> (state != S_IDLE), "store written while idle")
  `PFCC_ASSERT(a_sweep_bound, sweeping |-> (sweep_ptr < sweep_end), "sweep pointer past end")
  `PFCC_ASSERT(a_no_out_clear, (state == S_CLEAR) |-> !out_valid, "result beat during clear")
  `PFCC_ASSERT_NEXT(a_prog, state == S_RD && it_cmd && cs == CS_PROGRAM, cs == CS_READ, "program stuck")

endmodule

/* bench/parallel_flash_command_controller_core_test.sv */
// self-checking bench for the flash command controller: random accesses, command sequences, erases
module parallel_flash_command_controller_core_test;
  import pfcc_pkg::*;

  // command states as seen on the mode port
  localparam logic [3:0] MODE_READ    = 4'd0;
  localparam logic [3:0] MODE_SECOND  = 4'd1;
  localparam logic [3:0] MODE_THIRD   = 4'd2;
  localparam logic [3:0] MODE_AUTOSEL = 4'd3;
  localparam logic [3:0] MODE_PROGRAM = 4'd4;
  localparam logic [3:0] MODE_ERASE1  = 4'd5;
  localparam logic [3:0] MODE_ERASE2  = 4'd6;
  localparam logic [3:0] MODE_ERASE   = 4'd7;

  localparam int POOL_SIZE = 24;

  typedef enum int { ACT_NONE, ACT_PROGRAM, ACT_CHIP_ERASE, ACT_SECTOR_ERASE } store_action_t;

  typedef struct packed {
    logic                 is_write;
    logic [BANK_IN_W-1:0] bank;
    logic [OFF_W-1:0]     off;
    logic [7:0]           data;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [3:0] mode;
  } flash_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_data = CHIP_AM040;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = 1'b0;
  logic [BANK_IN_W-1:0] bank = '0;
  logic [OFF_W-1:0]     offset = '0;
  logic [7:0]           wdata = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           rdata;
  logic [3:0]           mode;

  parallel_flash_command_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .bank      (bank),
    .offset    (offset),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (rdata),
    .mode      (mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block, advanced at each accepted access
  bit [7:0]      flash_image [STORE_BYTES];
  logic [1:0]    chip_sel = CHIP_AM040;
  logic [3:0]    flash_mode = MODE_READ;
  flash_result_t due_results [$];

  // stimulus planning state
  access_t       access_queue [$];
  logic [1:0]    gen_chip = CHIP_AM040;
  logic [3:0]    plan_mode = MODE_READ;
  int            erase_budget;
  int            planned;
  logic [BANK_IN_W-1:0] pool_bank [POOL_SIZE];
  logic [OFF_W-1:0]     pool_off [POOL_SIZE];

  int errors;

  function automatic int chip_banks(input logic [1:0] ct);
    int n;
    case (ct)
      CHIP_AM010: n = 16;
      CHIP_AM020: n = 32;
      CHIP_AM040: n = 64;
      default:    n = 0;
    endcase
    return (n > MAX_BANKS) ? MAX_BANKS : n;
  endfunction

  // command state machine step for one write beat
  function automatic void next_command(input logic [3:0] cur, input logic [CADDR_W-1:0] caddr,
                                       input logic [7:0] v, output logic [3:0] nxt,
                                       output store_action_t act);
    nxt = (cur == MODE_AUTOSEL) ? MODE_READ : cur;
    act = ACT_NONE;
    case (nxt)
      MODE_READ: begin
        if (caddr == UNLOCK1_ADDR && v == UNLOCK1_DATA) nxt = MODE_SECOND;
      end
      MODE_SECOND: begin
        if (caddr == UNLOCK2_ADDR && v == UNLOCK2_DATA) nxt = MODE_THIRD;
      end
      MODE_THIRD: begin
        if (caddr == UNLOCK1_ADDR) begin
          if (v == CMD_AUTOSEL) nxt = MODE_AUTOSEL;
          else if (v == CMD_PROGRAM) nxt = MODE_PROGRAM;
          else if (v == CMD_ERASE) nxt = MODE_ERASE1;
        end
      end
      MODE_PROGRAM: begin
        act = ACT_PROGRAM;
        nxt = MODE_READ;
      end
      MODE_ERASE1: begin
        if (caddr == UNLOCK1_ADDR && v == UNLOCK1_DATA) nxt = MODE_ERASE2;
      end
      MODE_ERASE2: begin
        if (caddr == UNLOCK2_ADDR && v == UNLOCK2_DATA) nxt = MODE_ERASE;
      end
      MODE_ERASE: begin
        if (caddr == UNLOCK1_ADDR && v == CMD_CHIP_ERASE) begin
          act = ACT_CHIP_ERASE;
          nxt = MODE_READ;
        end else if (v == CMD_SECTOR_ERASE) begin
          act = ACT_SECTOR_ERASE;
          nxt = MODE_READ;
        end
      end
      default: begin
        if (v == CMD_RESET) nxt = MODE_READ;
      end
    endcase
  endfunction

  function automatic void wipe(input int start, input int len);
    int limit;
    int stop;
    limit = chip_banks(chip_sel) * BANK_BYTES;
    if (start >= limit) return;
    stop = (start + len > limit) ? limit : start + len;
    for (int i = start; i < stop; i++) flash_image[i] = ERASED_BYTE;
  endfunction

  // expected rdata/mode for one accepted beat; updates the shadow store
  function automatic void predict_access(input access_t a);
    int            nb;
    int            daddr;
    logic [3:0]    nxt;
    store_action_t act;
    flash_result_t r;
    nb = chip_banks(chip_sel);
    daddr = (nb != 0) ? (int'(a.bank) % nb) * BANK_BYTES + int'(a.off) : 0;
    r.rdata = 8'h00;
    if (!a.is_write) begin
      r.rdata = (nb != 0) ? flash_image[daddr] : ERASED_BYTE;
      if (flash_mode == MODE_AUTOSEL) begin
        if (a.off[7:0] == 8'h00)
          r.rdata = (nb != 0) ? MFR_ID : 8'h00;
        else if (a.off[7:0] == 8'h01)
          r.rdata = (chip_sel == CHIP_AM010) ? DEV_ID_AM010 :
                    (chip_sel == CHIP_AM040) ? DEV_ID_AM040 : 8'h00;
      end
    end else begin
      next_command(flash_mode, {a.bank[2:0], a.off}, a.data, nxt, act);
      flash_mode = nxt;
      case (act)
        ACT_PROGRAM: begin
          if (nb != 0) flash_image[daddr] = flash_image[daddr] & a.data;
        end
        ACT_CHIP_ERASE: wipe(0, nb * BANK_BYTES);
        ACT_SECTOR_ERASE: begin
          // the sector comes from the bank alone, the offset is not looked at
          if (chip_sel == CHIP_AM010)
            wipe((int'(a.bank[0]) * 4 + 1) << SECT16_SHIFT, 1 << SECT16_SHIFT);
          else if (chip_sel == CHIP_AM040)
            wipe(int'(a.bank[5:4]) << SECT64_SHIFT, 1 << SECT64_SHIFT);
        end
        default: ;
      endcase
    end
    r.mode = flash_mode;
    due_results.push_back(r);
  endfunction

  // sweep length of an erase under the chip type being planned
  function automatic int wipe_cost(input store_action_t act);
    case (act)
      ACT_CHIP_ERASE:   return chip_banks(gen_chip) * BANK_BYTES;
      ACT_SECTOR_ERASE: return (gen_chip == CHIP_AM010) ? (1 << SECT16_SHIFT) :
                               (gen_chip == CHIP_AM040) ? (1 << SECT64_SHIFT) : 0;
      default:          return 0;
    endcase
  endfunction

  // queue one beat; erases that would blow the cycle budget get their command byte nudged
  task automatic add_access(input logic w, input logic [BANK_IN_W-1:0] b,
                            input logic [OFF_W-1:0] o, input logic [7:0] v);
    access_t       a;
    logic [3:0]    nxt;
    store_action_t act;
    int            c;
    if (w) begin
      next_command(plan_mode, {b[2:0], o}, v, nxt, act);
      c = wipe_cost(act);
      // once in the erase path the only way out is an erase, so gate the entry
      if ((nxt == MODE_ERASE1 && plan_mode != MODE_ERASE1 &&
           wipe_cost(ACT_SECTOR_ERASE) > erase_budget) || c > erase_budget) begin
        v = v ^ 8'h01;
        next_command(plan_mode, {b[2:0], o}, v, nxt, act);
        c = wipe_cost(act);
      end
      erase_budget -= c;
      plan_mode = nxt;
    end
    a.is_write = w;
    a.bank = b;
    a.off = o;
    a.data = v;
    access_queue.push_back(a);
    planned++;
  endtask

  // write at a command address; upper bank bits do not matter there
  task automatic cmd_write(input logic [CADDR_W-1:0] caddr, input logic [7:0] v);
    add_access(1'b1, {3'($urandom_range(0, 7)), caddr[15:13]}, caddr[12:0], v);
  endtask

  task automatic unlock(input logic [7:0] command);
    cmd_write(UNLOCK1_ADDR, UNLOCK1_DATA);
    cmd_write(UNLOCK2_ADDR, UNLOCK2_DATA);
    cmd_write(UNLOCK1_ADDR, command);
  endtask

  task automatic add_program(input logic [BANK_IN_W-1:0] b, input logic [OFF_W-1:0] o,
                             input logic [7:0] v);
    unlock(CMD_PROGRAM);
    add_access(1'b1, b, o, v);
  endtask

  task automatic add_erase(input logic whole_chip);
    unlock(CMD_ERASE);
    cmd_write(UNLOCK1_ADDR, UNLOCK1_DATA);
    cmd_write(UNLOCK2_ADDR, UNLOCK2_DATA);
    if (whole_chip)
      cmd_write(UNLOCK1_ADDR, CMD_CHIP_ERASE);
    else
      add_access(1'b1, 6'($urandom), 13'($urandom), CMD_SECTOR_ERASE);
  endtask

  // mostly a small set of addresses so reads find programmed bytes
  task automatic pick_addr(output logic [BANK_IN_W-1:0] b, output logic [OFF_W-1:0] o);
    int k;
    if ($urandom_range(0, 9) == 0) begin
      b = 6'($urandom);
      o = 13'($urandom);
    end else begin
      k = $urandom_range(0, POOL_SIZE - 1);
      b = pool_bank[k];
      o = pool_off[k];
    end
  endtask

  task automatic add_random_item();
    logic [BANK_IN_W-1:0] b;
    logic [OFF_W-1:0]     o;
    logic [CADDR_W-1:0]   seq_addr [6];
    logic [7:0]           seq_data [6];
    int                   pick;
    int                   n;
    pick = $urandom_range(0, 99);
    pick_addr(b, o);
    if (pick < 35) begin
      add_access(1'b0, b, o, 8'($urandom));
    end else if (pick < 55) begin
      add_program(b, o, 8'($urandom));
      if ($urandom_range(0, 1)) add_access(1'b0, b, o, 8'($urandom));
    end else if (pick < 62) begin
      // id reads: low offset byte 0 and 1 give the ids, anything else the store
      unlock(CMD_AUTOSEL);
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: add_access(1'b0, 6'($urandom), 13'($urandom_range(0, 31)) << 8, 8'($urandom));
          1: add_access(1'b0, 6'($urandom),
                        (13'($urandom_range(0, 31)) << 8) | 13'd1, 8'($urandom));
          default: begin
            pick_addr(b, o);
            add_access(1'b0, b, o, 8'($urandom));
          end
        endcase
      end
    end else if (pick < 67) begin
      add_erase($urandom_range(0, 1) && wipe_cost(ACT_CHIP_ERASE) <= erase_budget);
    end else if (pick < 82) begin
      // truncated or corrupted command sequence
      seq_addr = '{UNLOCK1_ADDR, UNLOCK2_ADDR, UNLOCK1_ADDR, UNLOCK1_ADDR, UNLOCK2_ADDR,
                   UNLOCK1_ADDR};
      seq_data = '{UNLOCK1_DATA, UNLOCK2_DATA, CMD_ERASE, UNLOCK1_DATA, UNLOCK2_DATA,
                   CMD_CHIP_ERASE};
      case ($urandom_range(0, 2))
        0: seq_data[2] = CMD_AUTOSEL;
        1: seq_data[2] = CMD_PROGRAM;
        default: ;
      endcase
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1))
            seq_data[i] = seq_data[i] ^ (8'd1 << $urandom_range(0, 7));
          else
            seq_addr[i] = seq_addr[i] ^ (16'd1 << $urandom_range(0, 15));
        end
        cmd_write(seq_addr[i], seq_data[i]);
      end
    end else if (pick < 92) begin
      add_access(1'b1, 6'($urandom), 13'($urandom),
                 ($urandom_range(0, 4) == 0) ? CMD_RESET : 8'($urandom));
    end else begin
      add_access(1'b0, 6'($urandom), 13'($urandom), 8'($urandom));
    end
  endtask

  task automatic fill_random(input int n);
    int target;
    target = planned + n;
    while (planned < target) add_random_item();
  endtask

  // idle means nothing queued, nothing offered and nothing owed
  task automatic wait_drained();
    @(negedge clk);
    while (access_queue.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_chip(input logic [1:0] ct, input int budget);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ct;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chip_sel = ct;
    gen_chip = ct;
    erase_budget = budget;
  endtask

  // sender: bursts of beats with random gaps, fed from access_queue
  always @(posedge clk) begin : access_driver
    int      burst_left;
    int      gap_left;
    access_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_access('{cmd, bank, offset, wdata});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          nxt = access_queue.pop_front();
          cmd <= nxt.is_write;
          bank <= nxt.bank;
          offset <= nxt.off;
          wdata <= nxt.data;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall style changes every so often, plus one long hold-off
  always @(posedge clk) begin : result_monitor
    int            style;
    int            style_left;
    int            hold_left;
    int            results_seen;
    bit            held_once;
    flash_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      style = 0;
      style_left = 0;
      hold_left = 0;
      results_seen = 0;
      held_once = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: expected none, actual rdata=%02h mode=%0d",
                   $time, rdata, mode);
        end else begin
          want = due_results.pop_front();
          if (rdata !== want.rdata) begin
            errors++;
            $display("%0t rdata mismatch: expected %02h, actual %02h", $time, want.rdata, rdata);
          end
          if (mode !== want.mode) begin
            errors++;
            $display("%0t mode mismatch: expected %0d, actual %0d", $time, want.mode, mode);
          end
        end
        results_seen++;
      end
      // long hold-off so the block backs up and stalls its input
      if (!held_once && results_seen == 450) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 120);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= !out_stall;
        endcase
      end
    end
  end

  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    errors = 0;
    planned = 0;
    foreach (flash_image[i]) flash_image[i] = ERASED_BYTE;
    pool_bank[0] = 6'd63;
    pool_off[0] = 13'h1FFF;
    pool_bank[1] = 6'd0;
    pool_off[1] = 13'h0000;
    for (int k = 2; k < POOL_SIZE; k++) begin
      pool_bank[k] = 6'($urandom);
      pool_off[k] = 13'($urandom);
    end
    // land some entries in the erasable sectors
    pool_bank[2] = 6'd2;
    pool_bank[3] = 6'd10;
    pool_bank[4] = 6'd24;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset keeps in_stall high
    @(negedge clk);
    while (in_stall) @(negedge clk);

    // default chip, directed opening
    set_chip(CHIP_AM040, 140000);
    add_access(1'b0, 6'd63, 13'h1FFF, 8'h00);
    add_access(1'b0, 6'd0, 13'h0000, 8'hFF);
    add_access(1'b1, 6'd5, 13'd100, CMD_RESET);
    unlock(CMD_AUTOSEL);
    add_access(1'b0, 6'd63, 13'h1F00, 8'h00);
    add_access(1'b0, 6'd0, 13'h0001, 8'h00);
    add_access(1'b0, 6'd0, 13'h1FFF, 8'h00);
    // a write while in autoselect drops to read first and is then decoded
    unlock(CMD_PROGRAM);
    add_access(1'b1, 6'd63, 13'h1FFF, 8'h00);
    add_access(1'b0, 6'd63, 13'h1FFF, 8'h00);
    add_program(6'd24, 13'h0000, 8'h5A);
    add_access(1'b0, 6'd24, 13'h0000, 8'h00);
    add_erase(1'b0);
    add_access(1'b0, 6'd24, 13'h0000, 8'h00);
    fill_random(300);

    // 16-bank chip: banks wrap, small sectors, whole-chip erase
    wait_drained();
    set_chip(CHIP_AM010, 200000);
    add_program(6'd3, 13'd5, 8'h0F);
    add_access(1'b0, 6'd19, 13'd5, 8'h00);
    add_erase(1'b1);
    add_access(1'b0, 6'd3, 13'd5, 8'h00);
    fill_random(350);

    // no chip: reads give 0xff, programs and erases do nothing
    wait_drained();
    set_chip(CHIP_NONE, 0);
    fill_random(300);

    // 32-bank chip: sector erase is a no-op, whole-chip erase too slow to afford
    wait_drained();
    set_chip(CHIP_AM020, 0);
    fill_random(280);

    wait_drained();
    set_chip(CHIP_AM040, 70000);
    fill_random(300);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/pfcc_pkg.sv
hdl/parallel_flash_command_controller_core.sv
bench/parallel_flash_command_controller_core_test.sv
